[hdl/cflc_pkg.sv]
`timescale 1ns / 1ps

package cflc_pkg;

   // Field widths of one result beat.
   localparam int LEN_W   = 17;
   localparam int COUNT_W = 32;

   localparam logic [LEN_W-1:0] COUNT_MAX = {LEN_W{1'b1}};

   // Header bytes kept at fixed positions: enough for both cooked headers and
   // the IP length fields that follow them.
   localparam int FIXED_BYTES = 26;

   // Bytes of an IP header captured after the ethernet tag walk.
   localparam int ETH_IP_BYTES = 6;

   // Position of the first ethertype in an ethernet header, and tag stride.
   localparam int ETH_TYPE_POS = 12;
   localparam int TAG_STRIDE   = 4;

   // Header start positions and the byte counts the link checks need.
   localparam logic [LEN_W-1:0] ETH_MIN     = 17'd14;
   localparam logic [LEN_W-1:0] COOKED1_POS = 17'd16;
   localparam logic [LEN_W-1:0] COOKED2_POS = 17'd20;

   // IP header facts.
   localparam logic [3:0]       IP_V4        = 4'd4;
   localparam logic [3:0]       IP_V6        = 4'd6;
   localparam logic [15:0]      IPV4_MIN_LEN = 16'd20;
   localparam logic [LEN_W-1:0] IPV6_HDR_LEN = 17'd40;
   localparam logic [LEN_W-1:0] V4_LEN_END   = 17'd4;
   localparam logic [LEN_W-1:0] V6_LEN_END   = 17'd6;

   // Ethertypes.
   localparam logic [15:0] TYPE_IPV4 = 16'h0800;
   localparam logic [15:0] TYPE_IPV6 = 16'h86dd;
   localparam logic [15:0] TYPE_ARP  = 16'h0806;
   localparam logic [15:0] TYPE_VLAN = 16'h8100;
   localparam logic [15:0] TYPE_QINQ = 16'h88a8;
   localparam logic [15:0] TYPE_TAG9 = 16'h9100;

   // Cooked header limits.
   localparam logic [15:0] COOKED_PKT_MAX  = 16'd4;
   localparam logic [15:0] COOKED_ADDR_MAX = 16'd8;

   typedef enum logic [1:0] {
      CMD_BYTE   = 2'd0,
      CMD_START  = 2'd1,
      CMD_FINISH = 2'd2
   } cflc_cmd_type;

   typedef enum logic [1:0] {
      ST_IDLE    = 2'd0,
      ST_COLLECT = 2'd1,
      ST_ACCEPT  = 2'd2,
      ST_SKIP    = 2'd3
   } cflc_status_type;

   typedef enum logic [2:0] {
      LINK_NONE    = 3'd0,
      LINK_ETH     = 3'd1,
      LINK_RAW     = 3'd2,
      LINK_COOKED1 = 3'd3,
      LINK_COOKED2 = 3'd4
   } cflc_link_type;

   typedef enum logic [1:0] {
      ETH_WALK = 2'd0,
      ETH_IP   = 2'd1,
      ETH_NONE = 2'd2
   } cflc_eth_type;

   typedef logic [FIXED_BYTES-1:0][7:0]  cflc_fixed_type;
   typedef logic [ETH_IP_BYTES-1:0][7:0] cflc_ipbytes_type;

   // Control from the frame tracker to the header parser.
   typedef struct packed {
      logic             commit;
      logic             write;
      logic             restart;
      logic [7:0]       data;
      logic [LEN_W-1:0] pos;
      logic [LEN_W-1:0] count;
   } cflc_ctl_type;

   // Parser verdict for the bytes held so far.
   typedef struct packed {
      cflc_link_type    link_type;
      logic [LEN_W-1:0] exp_len;
   } cflc_view_type;

   typedef struct packed {
      cflc_status_type    status;
      cflc_link_type      link_type;
      logic [LEN_W-1:0]   exp_len;
      logic [LEN_W-1:0]   seen;
      logic [COUNT_W-1:0] good;
      logic [COUNT_W-1:0] bad;
   } cflc_result_type;

   function automatic logic is_ip(input logic [15:0] t);
      return (t == TYPE_IPV4) || (t == TYPE_IPV6);
   endfunction

   function automatic logic is_ip_arp(input logic [15:0] t);
      return is_ip(t) || (t == TYPE_ARP);
   endfunction

   function automatic logic is_tag(input logic [15:0] t);
      return (t == TYPE_VLAN) || (t == TYPE_QINQ) || (t == TYPE_TAG9);
   endfunction

   // Big-endian word at a fixed header position.
   function automatic logic [15:0] fixed_word(input cflc_fixed_type h, input int unsigned at);
      return {h[at], h[at + 1]};
   endfunction

   // Link layer guess from the first header bytes, n of them valid.
   function automatic cflc_link_type guess_link(input cflc_fixed_type h,
                                                input logic [LEN_W-1:0] n);
      cflc_link_type link;
      link = LINK_NONE;
      if (n >= COOKED2_POS && is_ip_arp(fixed_word(h, 0)) && fixed_word(h, 2) == 16'd0 &&
          h[10] <= COOKED_PKT_MAX[7:0] && h[11] <= COOKED_ADDR_MAX[7:0]) begin
         link = LINK_COOKED2;
      end else if (n >= COOKED1_POS && fixed_word(h, 0) <= COOKED_PKT_MAX &&
                   fixed_word(h, 4) <= COOKED_ADDR_MAX && is_ip_arp(fixed_word(h, 14))) begin
         link = LINK_COOKED1;
      end else if (n >= ETH_MIN && (is_ip_arp(fixed_word(h, ETH_TYPE_POS)) ||
                                    is_tag(fixed_word(h, ETH_TYPE_POS)))) begin
         link = LINK_ETH;
      end else if (n != '0 && (h[0][7:4] == IP_V4 || h[0][7:4] == IP_V6)) begin
         link = LINK_RAW;
      end
      return link;
   endfunction

   // Total frame length predicted from an IP header at start; avail is the
   // count of header bytes held from start on.
   function automatic logic [LEN_W-1:0] ip_length(input logic ok,
                                                  input logic [LEN_W-1:0] start,
                                                  input logic [LEN_W-1:0] avail,
                                                  input logic [7:0] first,
                                                  input logic [15:0] v4_len,
                                                  input logic [15:0] v6_len);
      logic [LEN_W-1:0] len;
      len = '0;
      if (ok && avail != '0) begin
         if (first[7:4] == IP_V4 && avail >= V4_LEN_END && v4_len >= IPV4_MIN_LEN) begin
            len = start + {1'b0, v4_len};
         end else if (first[7:4] == IP_V6 && avail >= V6_LEN_END) begin
            len = start + IPV6_HDR_LEN + {1'b0, v6_len};
         end
      end
      return len;
   endfunction

endpackage

[hdl/cflc_parse.sv]
`timescale 1ns / 1ps

module cflc_parse #(
   parameter int HDR_BYTES = 64,
   parameter int MAX_VLAN  = 8
) (
   input  logic                  clock,
   input  logic                  reset,
   input  cflc_pkg::cflc_ctl_type  ctl,
   output cflc_pkg::cflc_view_type view
);
   import cflc_pkg::*;

   localparam int PW = $clog2(HDR_BYTES + TAG_STRIDE * MAX_VLAN + 16);
   localparam int TW = $clog2(MAX_VLAN + 1);

   localparam logic [LEN_W-1:0] HDR_LIMIT  = LEN_W'(HDR_BYTES);
   localparam logic [TW-1:0]    TAG_LIMIT  = TW'(MAX_VLAN);
   localparam logic [PW-1:0]    FIRST_TYPE = PW'(ETH_TYPE_POS);
   localparam logic [PW-1:0]    STRIDE     = PW'(TAG_STRIDE);
   localparam logic [PW-1:0]    IP_SPAN    = PW'(ETH_IP_BYTES);

   logic [LEN_W-1:0] held;
   logic             store;
   logic [PW-1:0]    pos;

   cflc_fixed_type   hdr_ff, hdr_in;

   cflc_eth_type     eth_state_ff, eth_state_in;
   logic [TW-1:0]    eth_tags_ff, eth_tags_in;
   logic [PW-1:0]    eth_chain_ff, eth_chain_in;
   logic [PW-1:0]    eth_start_ff, eth_start_in;
   logic [7:0]       eth_hi_ff, eth_hi_in;
   cflc_ipbytes_type eth_ip_ff, eth_ip_in;
   logic             eth_ok;

   logic             c1_ok, c2_ok;
   logic [LEN_W-1:0] eth_start;
   logic [LEN_W-1:0] raw_len, c1_len, c2_len, eth_len;

   // Bytes held for the header checks; later bytes are counted but dropped.
   assign held  = (ctl.count < HDR_LIMIT) ? ctl.count : HDR_LIMIT;
   assign store = ctl.write && (ctl.pos < HDR_LIMIT);
   assign pos   = ctl.pos[PW-1:0];

   // Header bytes at fixed positions, including the beat in flight.
   always_comb begin
      hdr_in = hdr_ff;
      for (int i = 0; i < FIXED_BYTES; i++) begin
         if (store && ctl.pos == LEN_W'(i)) begin
            hdr_in[i] = ctl.data;
         end
      end
   end

   // Ethernet tag walk: next state.
   always_comb begin
      logic [15:0]   eth_type;
      logic [PW-1:0] eth_rel;
      eth_state_in = eth_state_ff;
      eth_tags_in  = eth_tags_ff;
      eth_chain_in = eth_chain_ff;
      eth_start_in = eth_start_ff;
      eth_hi_in    = eth_hi_ff;
      eth_ip_in    = eth_ip_ff;
      eth_type     = {eth_hi_ff, ctl.data};
      eth_rel      = pos - eth_start_ff;
      if (ctl.restart) begin
         eth_state_in = ETH_WALK;
         eth_tags_in  = '0;
         eth_chain_in = FIRST_TYPE;
      end else if (store) begin
         case (eth_state_ff)
            ETH_WALK: begin
               if (pos == eth_chain_ff) begin
                  eth_hi_in = ctl.data;
               end else if (pos == eth_chain_ff + PW'(1)) begin
                  if (is_tag(eth_type)) begin
                     if (eth_tags_ff == TAG_LIMIT) begin
                        eth_state_in = ETH_NONE;
                     end else begin
                        eth_tags_in  = eth_tags_ff + TW'(1);
                        eth_chain_in = eth_chain_ff + STRIDE;
                     end
                  end else if (is_ip(eth_type)) begin
                     eth_state_in = ETH_IP;
                     eth_start_in = eth_chain_ff + PW'(2);
                  end else begin
                     eth_state_in = ETH_NONE;
                  end
               end
            end
            ETH_IP: begin
               if (pos >= eth_start_ff && eth_rel < IP_SPAN) begin
                  eth_ip_in[eth_rel[2:0]] = ctl.data;
               end
            end
            default: ;
         endcase
      end
   end

   // Ethernet tag walk: outputs. A start beat still closes the frame that the
   // current walk state describes.
   always_comb begin
      eth_ok    = ctl.restart ? (eth_state_ff == ETH_IP) : (eth_state_in == ETH_IP);
      eth_start = LEN_W'(eth_start_in);
   end

   // Length prediction for each link candidate, then the pick by link type.
   always_comb begin
      c1_ok   = (held >= COOKED1_POS) && is_ip(fixed_word(hdr_in, 14));
      c2_ok   = (held >= COOKED2_POS) && is_ip(fixed_word(hdr_in, 0));
      raw_len = ip_length(1'b1, '0, held, hdr_in[0],
                          fixed_word(hdr_in, 2), fixed_word(hdr_in, 4));
      c1_len  = ip_length(c1_ok, COOKED1_POS, held - COOKED1_POS, hdr_in[16],
                          fixed_word(hdr_in, 18), fixed_word(hdr_in, 20));
      c2_len  = ip_length(c2_ok, COOKED2_POS, held - COOKED2_POS, hdr_in[20],
                          fixed_word(hdr_in, 22), fixed_word(hdr_in, 24));
      eth_len = ip_length(eth_ok, eth_start, held - eth_start, eth_ip_in[0],
                          {eth_ip_in[2], eth_ip_in[3]}, {eth_ip_in[4], eth_ip_in[5]});
      view.link_type = guess_link(hdr_in, held);
      case (view.link_type)
         LINK_RAW:     view.exp_len = raw_len;
         LINK_COOKED1: view.exp_len = c1_len;
         LINK_COOKED2: view.exp_len = c2_len;
         LINK_ETH:     view.exp_len = eth_len;
         default:      view.exp_len = '0;
      endcase
   end

   // Walk control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         eth_state_ff <= ETH_WALK;
         eth_tags_ff  <= '0;
         eth_chain_ff <= FIRST_TYPE;
      end else if (ctl.commit) begin
         eth_state_ff <= eth_state_in;
         eth_tags_ff  <= eth_tags_in;
         eth_chain_ff <= eth_chain_in;
      end
   end

   // Captured header bytes.
   always_ff @(posedge clock) begin
      if (ctl.commit) begin
         hdr_ff       <= hdr_in;
         eth_start_ff <= eth_start_in;
         eth_hi_ff    <= eth_hi_in;
         eth_ip_ff    <= eth_ip_in;
      end
   end

endmodule

[hdl/cflc_frame.sv]
`timescale 1ns / 1ps

module cflc_frame (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      fire,
   input  logic [1:0]                cmd,
   input  logic [7:0]                data_byte,
   input  cflc_pkg::cflc_view_type   view,
   output cflc_pkg::cflc_ctl_type    ctl,
   output cflc_pkg::cflc_result_type result
);
   import cflc_pkg::*;

   logic               open_ff, open_in;
   logic [LEN_W-1:0]   cnt_ff, cnt_in;
   cflc_link_type      locked_ff, locked_in;
   logic [COUNT_W-1:0] good_ff, good_in;
   logic [COUNT_W-1:0] bad_ff, bad_in;

   logic               is_byte;
   logic [LEN_W-1:0]   cnt_view;
   logic               close;
   logic               skip;

   // Byte count including the beat in flight, saturating.
   assign is_byte  = open_ff && (cmd == CMD_BYTE);
   assign cnt_view = (is_byte && cnt_ff != COUNT_MAX) ? cnt_ff + LEN_W'(1) : cnt_ff;

   // Control for the header parser.
   always_comb begin
      ctl.commit  = fire;
      ctl.write   = is_byte;
      ctl.restart = (cmd == CMD_START);
      ctl.data    = data_byte;
      ctl.pos     = cnt_ff;
      ctl.count   = cnt_view;
   end

   // Skip rule for a closing frame.
   assign skip = (cnt_view == '0) || (view.link_type == LINK_NONE) ||
                 (view.exp_len != '0 && cnt_view < view.exp_len) ||
                 (locked_ff != LINK_NONE && locked_ff != view.link_type);

   // Command decode, frame close and the result beat.
   always_comb begin
      open_in          = open_ff;
      cnt_in           = cnt_ff;
      locked_in        = locked_ff;
      good_in          = good_ff;
      bad_in           = bad_ff;
      close            = 1'b0;
      result.status    = ST_IDLE;
      result.link_type = LINK_NONE;
      result.exp_len   = '0;
      result.seen      = '0;
      case (cmd)
         CMD_START: begin
            if (open_ff) begin
               close = 1'b1;
            end else begin
               result.status = ST_COLLECT;
            end
            open_in = 1'b1;
            cnt_in  = '0;
         end
         CMD_FINISH: begin
            close   = open_ff;
            open_in = 1'b0;
            cnt_in  = '0;
         end
         CMD_BYTE: begin
            if (open_ff) begin
               if (view.exp_len != '0 && cnt_view >= view.exp_len) begin
                  close   = 1'b1;
                  open_in = 1'b0;
                  cnt_in  = '0;
               end else begin
                  cnt_in           = cnt_view;
                  result.status    = ST_COLLECT;
                  result.link_type = view.link_type;
                  result.exp_len   = view.exp_len;
                  result.seen      = cnt_view;
               end
            end
         end
         default: begin
            if (open_ff) begin
               result.status    = ST_COLLECT;
               result.link_type = view.link_type;
               result.exp_len   = view.exp_len;
               result.seen      = cnt_view;
            end
         end
      endcase
      if (close) begin
         result.link_type = view.link_type;
         result.exp_len   = view.exp_len;
         result.seen      = cnt_view;
         if (skip) begin
            bad_in        = bad_ff + COUNT_W'(1);
            result.status = ST_SKIP;
         end else begin
            if (locked_ff == LINK_NONE) begin
               locked_in = view.link_type;
            end
            good_in       = good_ff + COUNT_W'(1);
            result.status = ST_ACCEPT;
         end
      end
      result.good = good_in;
      result.bad  = bad_in;
   end

   // Frame state and totals.
   always_ff @(posedge clock) begin
      if (reset) begin
         open_ff   <= 1'b0;
         cnt_ff    <= '0;
         locked_ff <= LINK_NONE;
         good_ff   <= '0;
         bad_ff    <= '0;
      end else if (fire) begin
         open_ff   <= open_in;
         cnt_ff    <= cnt_in;
         locked_ff <= locked_in;
         good_ff   <= good_in;
         bad_ff    <= bad_in;
      end
   end

endmodule

[hdl/capture_frame_link_classifier.sv]
`timescale 1ns / 1ps

// Channel   Direction  Handshake            Payload
// req       in         req_valid/req_stall  req_cmd, req_data_byte
// rsp       out        rsp_valid/rsp_stall  rsp_status, rsp_link_type, rsp_expected_length,
//                                           rsp_bytes_seen, rsp_accepted_count,
//                                           rsp_skipped_count
//
// Each request beat gives exactly one response beat: an accepted beat waits in the input
// register, and its result is then registered and shows on the response ports.
// A new beat is accepted every cycle while no stalled response waits; the header checks
// and the length prediction sit in one combinational pass between the two registers.
// Reset is synchronous and clears frame state, the link lock and both totals.
// A stalled response holds the pipeline; req_stall rises only while a response waits.

module capture_frame_link_classifier #(
   parameter int HDR_BYTES = 64,
   parameter int MAX_VLAN  = 8
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_cmd,
   input  logic [7:0]  req_data_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_status,
   output logic [2:0]  rsp_link_type,
   output logic [16:0] rsp_expected_length,
   output logic [16:0] rsp_bytes_seen,
   output logic [31:0] rsp_accepted_count,
   output logic [31:0] rsp_skipped_count
);
   import cflc_pkg::*;

   logic            in_valid_ff, in_valid_in;
   logic [1:0]      cmd_ff;
   logic [7:0]      data_ff;
   logic            rsp_valid_ff, rsp_valid_in;
   cflc_result_type rsp_ff;

   logic            accept;
   logic            advance;
   cflc_ctl_type    ctl;
   cflc_view_type   view;
   cflc_result_type result;

   // Beat flow through the input and response registers.
   assign advance     = in_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall   = in_valid_ff && !advance;
   assign accept      = req_valid && !req_stall;
   assign in_valid_in = accept ? 1'b1 : (advance ? 1'b0 : in_valid_ff);
   assign rsp_valid_in = advance ? 1'b1 : (rsp_stall ? rsp_valid_ff : 1'b0);

   cflc_parse #(
      .HDR_BYTES(HDR_BYTES),
      .MAX_VLAN (MAX_VLAN)
   ) u_parse (
      .clock(clock),
      .reset(reset),
      .ctl  (ctl),
      .view (view)
   );

   cflc_frame u_frame (
      .clock    (clock),
      .reset    (reset),
      .fire     (advance),
      .cmd      (cmd_ff),
      .data_byte(data_ff),
      .view     (view),
      .ctl      (ctl),
      .result   (result)
   );

   // Valid flags.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Input and response payload.
   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_ff  <= req_cmd;
         data_ff <= req_data_byte;
      end
      if (advance) begin
         rsp_ff <= result;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_status          = rsp_ff.status;
   assign rsp_link_type       = rsp_ff.link_type;
   assign rsp_expected_length = rsp_ff.exp_len;
   assign rsp_bytes_seen      = rsp_ff.seen;
   assign rsp_accepted_count  = rsp_ff.good;
   assign rsp_skipped_count   = rsp_ff.bad;

endmodule

[hdl/cflc_checker.sv]
`timescale 1ns / 1ps

module cflc_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic [1:0]  req_cmd,
   input logic [7:0]  req_data_byte,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [1:0]  rsp_status,
   input logic [2:0]  rsp_link_type,
   input logic [16:0] rsp_expected_length,
   input logic [16:0] rsp_bytes_seen,
   input logic [31:0] rsp_accepted_count,
   input logic [31:0] rsp_skipped_count
);
   import cflc_pkg::*;

   // A stalled response beat stays in place.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_status) &&
      $stable(rsp_bytes_seen) && $stable(rsp_accepted_count))
      else $error("stalled response beat changed");

   // Requests back up only behind a waiting response.
   assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("request stalled with no waiting response");

   // Without an open frame the frame fields read zero.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == ST_IDLE |->
      rsp_link_type == LINK_NONE && rsp_expected_length == '0 && rsp_bytes_seen == '0)
      else $error("idle response carries frame fields");

   // An accepted frame has bytes and a link type.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == ST_ACCEPT |->
      rsp_link_type != LINK_NONE && rsp_bytes_seen != '0)
      else $error("frame accepted without bytes or link");

   // A frame still collecting has not reached its predicted length.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == ST_COLLECT && rsp_expected_length != '0 |->
      rsp_bytes_seen < rsp_expected_length)
      else $error("complete frame left open");

endmodule

bind capture_frame_link_classifier cflc_checker u_checker (.*);
